// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and codes of the I2C register access master
// Request and response payloads, command codes and the bus sequencer steps.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command codes carried by a request.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Byte slots of a transaction.
  localparam logic [1:0] BYTE_ADDR   = 2'd0;
  localparam logic [1:0] BYTE_REG    = 2'd1;
  localparam logic [1:0] BYTE_THIRD  = 2'd2;
  localparam logic [1:0] BYTE_RXDATA = 2'd3;

  // Read status codes.
  localparam logic [1:0] STATUS_OK = 2'd0;

  localparam int unsigned PHASE_W = 16;

  // One request: a timing tick with an optional start command.
  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic [2:0] ack_check_mask;
    logic       sda_in;
  } req_t;

  // One response: bus line levels and transaction results after the tick.
  typedef struct packed {
    logic       scl_out;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic [2:0] nack_flags;
  } rsp_t;

  // Bus sequencer steps, one-hot.
  typedef enum logic [16:0] {
    ST_IDLE = 17'b00000000000000001,
    ST_S0   = 17'b00000000000000010,
    ST_S1   = 17'b00000000000000100,
    ST_S2   = 17'b00000000000001000,
    ST_S3   = 17'b00000000000010000,
    ST_B0   = 17'b00000000000100000,
    ST_B1   = 17'b00000000001000000,
    ST_B2   = 17'b00000000010000000,
    ST_A0   = 17'b00000000100000000,
    ST_A1   = 17'b00000001000000000,
    ST_A2   = 17'b00000010000000000,
    ST_N0   = 17'b00000100000000000,
    ST_N1   = 17'b00001000000000000,
    ST_N2   = 17'b00010000000000000,
    ST_P0   = 17'b00100000000000000,
    ST_P1   = 17'b01000000000000000,
    ST_P2   = 17'b10000000000000000
  } step_t;

endpackage

// ===== hw/rtl/i2cm_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_if: request and response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------

// Request channel into the master.
interface i2cm_req_if;
  logic           valid;
  logic           ready;
  i2cm_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Response channel out of the master.
interface i2cm_rsp_if;
  logic           valid;
  logic           ready;
  i2cm_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cm_seq: bus phase sequencer
// Holds the transaction state and advances it by one tick per request.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  i2cm_pkg::req_t                    req_data,
  input  logic [i2cm_pkg::PHASE_W-1:0]      phase_ticks,
  output i2cm_pkg::rsp_t                    rsp_next
);
  import i2cm_pkg::*;

  step_t              seq_step, seq_step_next, tgt;
  logic [PHASE_W-1:0] phase_count, phase_count_next, pc_inc, limit;
  logic [2:0]         bit_index, bit_index_next;
  logic [1:0]         byte_select, byte_select_next;
  logic [7:0]         rx_shift, rx_shift_next;
  logic [2:0]         nack_seen, nack_seen_next;
  logic               read_mode, read_mode_next;
  logic [6:0]         held_dev_addr, held_dev_addr_next;
  logic [7:0]         held_reg_addr, held_reg_addr_next;
  logic [7:0]         held_wr_data, held_wr_data_next;
  logic [2:0]         held_mask, held_mask_next;
  logic               scl_level, scl_level_next;
  logic               sda_low_level, sda_low_level_next;
  logic               ack_bit, ack_bit_next;
  logic [7:0]         read_byte, read_byte_next;
  logic [1:0]         status, status_next;
  logic [2:0]         nack_flags, nack_flags_next;
  logic               done;
  logic               apply;
  logic [7:0]         tx_byte;
  logic [3:0]         byte_onehot;

  // A zero phase length behaves as one tick.
  assign limit  = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;
  assign pc_inc = phase_count + PHASE_W'(1);
  assign byte_onehot = 4'b0001 << byte_select;

  // Next state: pick the next phase, then apply its line levels.
  always_comb begin
    seq_step_next      = seq_step;
    phase_count_next   = phase_count;
    bit_index_next     = bit_index;
    byte_select_next   = byte_select;
    rx_shift_next      = rx_shift;
    nack_seen_next     = nack_seen;
    read_mode_next     = read_mode;
    held_dev_addr_next = held_dev_addr;
    held_reg_addr_next = held_reg_addr;
    held_wr_data_next  = held_wr_data;
    held_mask_next     = held_mask;
    scl_level_next     = scl_level;
    sda_low_level_next = sda_low_level;
    ack_bit_next       = ack_bit;
    read_byte_next     = read_byte;
    status_next        = status;
    nack_flags_next    = nack_flags;
    done               = 1'b0;
    apply              = 1'b0;
    tgt                = seq_step;
    tx_byte            = 8'hFF;

    if (seq_step == ST_IDLE) begin
      // A start command latches the operands and raises SCL.
      if (req_data.cmd == CMD_WRITE || req_data.cmd == CMD_READ) begin
        held_dev_addr_next = req_data.dev_addr;
        held_reg_addr_next = req_data.reg_addr;
        held_wr_data_next  = req_data.wr_data;
        held_mask_next     = req_data.ack_check_mask;
        read_mode_next     = (req_data.cmd == CMD_READ);
        byte_select_next   = BYTE_ADDR;
        bit_index_next     = 3'd7;
        nack_seen_next     = 3'b000;
        rx_shift_next      = 8'h00;
        phase_count_next   = '0;
        if (req_data.cmd == CMD_READ) begin
          status_next = STATUS_OK;
        end
        apply = 1'b1;
        tgt   = ST_S0;
      end
    end else begin
      phase_count_next = pc_inc;
      if (pc_inc >= limit) begin
        phase_count_next = '0;
        apply            = 1'b1;
        case (seq_step)
          ST_S0: tgt = ST_S1;
          ST_S1: tgt = ST_S2;
          ST_S2: tgt = ST_S3;
          ST_S3: begin
            bit_index_next = 3'd7;
            tgt            = ST_B0;
          end
          ST_B0: tgt = ST_B1;
          ST_B1: tgt = ST_B2;
          ST_B2: begin
            if (bit_index == 3'd0) begin
              tgt = ST_A0;
            end else begin
              bit_index_next = bit_index - 3'd1;
              tgt            = ST_B0;
            end
          end
          ST_A0: tgt = ST_A1;
          ST_A1: tgt = ST_A2;
          ST_A2: begin
            // End of an acknowledge or received data bit.
            if (read_mode) begin
              if (byte_select == BYTE_RXDATA) begin
                if (bit_index == 3'd0) begin
                  tgt = ST_N0;
                end else begin
                  bit_index_next = bit_index - 3'd1;
                  tgt            = ST_A0;
                end
              end else if (ack_bit) begin
                status_next = byte_select + 2'd1;
                tgt         = ST_P0;
              end else begin
                byte_select_next = byte_select + 2'd1;
                bit_index_next   = 3'd7;
                case (byte_select)
                  BYTE_ADDR: tgt = ST_B0;
                  BYTE_REG:  tgt = ST_S0;
                  default: begin
                    rx_shift_next = 8'h00;
                    tgt           = ST_A0;
                  end
                endcase
              end
            end else begin
              nack_seen_next = nack_seen | (byte_onehot[2:0] & held_mask & {3{ack_bit}});
              if (byte_select >= BYTE_THIRD) begin
                tgt = ST_P0;
              end else begin
                byte_select_next = byte_select + 2'd1;
                bit_index_next   = 3'd7;
                tgt              = ST_B0;
              end
            end
          end
          ST_N0: tgt = ST_N1;
          ST_N1: tgt = ST_N2;
          ST_N2: tgt = ST_P0;
          ST_P0: tgt = ST_P1;
          ST_P1: tgt = ST_P2;
          default: begin
            // Hold after STOP is over: publish the results.
            tgt  = ST_IDLE;
            done = 1'b1;
            if (read_mode) begin
              if (status == STATUS_OK) begin
                read_byte_next = rx_shift;
              end
            end else begin
              nack_flags_next = nack_seen;
            end
          end
        endcase
      end
    end

    // Byte being shifted out, seen after the slot update.
    case (byte_select_next)
      BYTE_ADDR:  tx_byte = {held_dev_addr_next, 1'b0};
      BYTE_REG:   tx_byte = held_reg_addr_next;
      BYTE_THIRD: tx_byte = read_mode_next ? {held_dev_addr_next, 1'b1} : held_wr_data_next;
      default:    tx_byte = 8'hFF;
    endcase

    // Line levels set on entry to each phase.
    if (apply) begin
      seq_step_next = tgt;
      case (tgt)
        ST_S0, ST_B1, ST_A1, ST_N1, ST_P1: scl_level_next = 1'b1;
        ST_S1, ST_A0, ST_N0, ST_P2:        sda_low_level_next = 1'b0;
        ST_S2, ST_P0:                      sda_low_level_next = 1'b1;
        ST_S3, ST_B2, ST_N2:               scl_level_next = 1'b0;
        ST_B0: sda_low_level_next = ~tx_byte[bit_index_next];
        ST_A2: begin
          ack_bit_next = req_data.sda_in;
          if (read_mode_next && byte_select_next == BYTE_RXDATA) begin
            rx_shift_next = {rx_shift_next[6:0], req_data.sda_in};
          end
          scl_level_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Control state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_step      <= ST_IDLE;
      phase_count   <= '0;
      bit_index     <= 3'd0;
      byte_select   <= BYTE_ADDR;
      rx_shift      <= 8'h00;
      nack_seen     <= 3'b000;
      read_mode     <= 1'b0;
      scl_level     <= 1'b1;
      sda_low_level <= 1'b0;
      ack_bit       <= 1'b0;
      read_byte     <= 8'h00;
      status        <= STATUS_OK;
      nack_flags    <= 3'b000;
    end else if (step) begin
      seq_step      <= seq_step_next;
      phase_count   <= phase_count_next;
      bit_index     <= bit_index_next;
      byte_select   <= byte_select_next;
      rx_shift      <= rx_shift_next;
      nack_seen     <= nack_seen_next;
      read_mode     <= read_mode_next;
      scl_level     <= scl_level_next;
      sda_low_level <= sda_low_level_next;
      ack_bit       <= ack_bit_next;
      read_byte     <= read_byte_next;
      status        <= status_next;
      nack_flags    <= nack_flags_next;
    end
  end

  // Operands held for the transaction.
  always_ff @(posedge clk) begin
    if (step) begin
      held_dev_addr <= held_dev_addr_next;
      held_reg_addr <= held_reg_addr_next;
      held_wr_data  <= held_wr_data_next;
      held_mask     <= held_mask_next;
    end
  end

  // Response for this tick.
  always_comb begin
    rsp_next.scl_out      = scl_level_next;
    rsp_next.sda_pull_low = sda_low_level_next;
    rsp_next.busy_res     = (seq_step_next != ST_IDLE);
    rsp_next.done_res     = done;
    rsp_next.read_byte    = read_byte_next;
    rsp_next.status       = status_next;
    rsp_next.nack_flags   = nack_flags_next;
  end

endmodule

// ===== hw/rtl/i2cm_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// i2cm_rsp_reg: response output register
// Holds one response until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cm_rsp_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  i2cm_pkg::rsp_t din,
  output logic           can_load,
  i2cm_rsp_if.source     rsp
);
  import i2cm_pkg::*;

  logic valid;
  rsp_t data;

  // The register can take a new response when empty or being drained.
  assign can_load = !valid || rsp.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      data <= din;
    end
  end

  assign rsp.valid = valid;
  assign rsp.data  = data;

endmodule

// ===== hw/rtl/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access: I2C master for single register write or read
// Bit-banged I2C sequencer advanced by one request per tick.
// ----------------------------------------------------------------------------
// Usage: every request on req is one timing tick and carries the sampled SDA
// level. A tick in idle with a write or read command starts a transaction;
// commands while busy are ignored. Each bus phase lasts phase_ticks ticks,
// set through cfg_wr_en/cfg_wr_data while the block is idle (zero acts as 1).
// Every request yields exactly one response on rsp with the SCL level, the
// SDA pull-down, busy and done flags and the last read/write results.
// Latency: the response for a request is valid in the cycle after the
// request is accepted. Throughput: one request per clock cycle unless stalled;
// the whole tick update is one pass through the sequencer into its state registers.
// Reset: SCL high, SDA released, sequencer idle, results zero, phase_ticks 1.
// Stall: while a response waits and rsp.ready is low, req.ready stays low
// and the sequencer state holds.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [i2cm_pkg::PHASE_W-1:0]  cfg_wr_data,
  i2cm_req_if.sink                      req,
  i2cm_rsp_if.source                    rsp
);
  import i2cm_pkg::*;

  logic [PHASE_W-1:0] phase_ticks;
  logic               accept;
  logic               can_load;
  rsp_t               rsp_next;

  // Phase length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_W'(1);
    end else if (cfg_wr_en) begin
      phase_ticks <= cfg_wr_data;
    end
  end

  // Handshake: a request is taken when the response register has room.
  assign req.ready = can_load;
  assign accept    = req.valid && can_load;

  i2cm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .req_data    (req.data),
    .phase_ticks (phase_ticks),
    .rsp_next    (rsp_next)
  );

  i2cm_rsp_reg u_rsp_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .din      (rsp_next),
    .can_load (can_load),
    .rsp      (rsp)
  );

  // A finished transaction is never reported as still busy.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.done_res |-> !rsp.data.busy_res)
    else $error("done reported while busy");

  // A stalled response blocks new requests.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request taken while response stalled");

  // Every accepted request produces a response in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> rsp.valid)
    else $error("response missing after accepted request");

  // The bus lines hold steady while a response is stalled.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> $stable(rsp.data.scl_out) && $stable(rsp.data.sda_pull_low))
    else $error("bus levels changed without a request");

endmodule
